/* rtl/q14alu_pkg.sv */
// q14alu_pkg: shared types for the q14 fixed point arithmetic unit
// operation codes and the control group that travels with each pipeline stage
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package q14alu_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t  op;
        logic neg;
        logic dz;
    } stage_ctl_t;

endpackage

`default_nettype wire

/* rtl/q14alu_div_stage.sv */
// q14alu_div_stage: one registered step of the restoring divider, one quotient bit
// also carries the control group and the result of non-divide operations
// depends on q14alu_pkg
`timescale 1ns / 1ps
`default_nettype none

module q14alu_div_stage #(
    parameter int DVS_W = 16,
    parameter int QUO_W = 30
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   up_valid,
    output logic                        up_ready,
    input  wire q14alu_pkg::stage_ctl_t up_ctl,
    input  wire logic [DVS_W-1:0]       up_rem,
    input  wire logic [QUO_W-1:0]       up_quo,
    input  wire logic [DVS_W-1:0]       up_dvs,
    input  wire logic [DVS_W-1:0]       up_res,
    output logic                        dn_valid,
    input  wire logic                   dn_ready,
    output q14alu_pkg::stage_ctl_t      dn_ctl,
    output logic [DVS_W-1:0]            dn_rem,
    output logic [QUO_W-1:0]            dn_quo,
    output logic [DVS_W-1:0]            dn_dvs,
    output logic [DVS_W-1:0]            dn_res
);
    import q14alu_pkg::*;

    logic               valid_reg;
    stage_ctl_t         ctl_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W-1:0]   res_reg;

    logic [DVS_W:0]     shifted;
    logic [DVS_W:0]     trial;
    logic               take;
    logic [DVS_W-1:0]   rem_next;
    logic [QUO_W-1:0]   quo_next;

    always_comb
    begin
        shifted  = {up_rem, up_quo[QUO_W-1]};
        trial    = shifted - {1'b0, up_dvs};
        take     = ~trial[DVS_W];
        rem_next = take ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo_next = {up_quo[QUO_W-2:0], take};
    end

    assign up_ready = ~valid_reg | dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ctl_reg <= up_ctl;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dvs_reg <= up_dvs;
            res_reg <= up_res;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_rem   = rem_reg;
    assign dn_quo   = quo_reg;
    assign dn_dvs   = dvs_reg;
    assign dn_res   = res_reg;

endmodule

`default_nettype wire

/* rtl/q14_fixed_point_alu.sv */
// q14_fixed_point_alu: pipelined signed fixed point add, subtract, multiply, divide
// input register with multiplier, prep logic, a chain of divider stages, output register
// depends on q14alu_pkg and q14alu_div_stage
//
//   channel  | signals                          | role
//   ---------+----------------------------------+------------------------------
//   request  | req_valid req_stall op a b       | one operation, two operands
//   response | rsp_valid rsp_stall result       | one result per request
//            | div_by_zero                      |
//
// every operation passes through the whole divider chain, whose length is
// set by the restoring divider that resolves one quotient bit per stage
// a new request is taken every cycle unless stalled; each stage holds its own valid bit
// reset clears all valid bits; stalls pass back combinationally, empty stages fill bubbles
`timescale 1ns / 1ps
`default_nettype none

module q14_fixed_point_alu #(
    parameter int FRAC_BITS = 14,
    parameter int WORD_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire q14alu_pkg::op_t        op,
    input  wire logic [WORD_BITS-1:0]   a,
    input  wire logic [WORD_BITS-1:0]   b,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output logic [WORD_BITS-1:0]        result,
    output logic                        div_by_zero
);
    import q14alu_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int MW = WORD_BITS + FRAC_BITS;
    localparam int PW = 2 * WORD_BITS + FRAC_BITS;
    localparam logic signed [W:0] SAT_HI = {2'b00, {(W - 1){1'b1}}};
    localparam logic signed [W:0] SAT_LO = -SAT_HI;
    localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (FRAC_BITS - 1);

    // input stage
    logic                       in_valid_reg;
    op_t                        op_reg;
    logic signed [W-1:0]        a_reg;
    logic signed [W-1:0]        b_reg;
    logic signed [2*W-1:0]      prod_reg;
    logic                       in_ready;

    // divider chain
    logic                       valid_c [MW+1];
    logic                       ready_c [MW+1];
    stage_ctl_t                 ctl_c   [MW+1];
    logic [W-1:0]               rem_c   [MW+1];
    logic [MW-1:0]              quo_c   [MW+1];
    logic [W-1:0]               dvs_c   [MW+1];
    logic [W-1:0]               res_c   [MW+1];

    // prep logic
    logic signed [W:0]          sum;
    logic signed [PW-1:0]       prod_rnd;
    logic [W-1:0]               abs_a;
    logic [W-1:0]               abs_b;
    logic [W-1:0]               prep_res;

    // output stage
    logic                       out_valid_reg;
    logic [W-1:0]               result_reg;
    logic                       dz_reg;
    logic                       out_ready;
    logic [W-1:0]               final_res;
    logic [W-1:0]               quo_low;

    assign in_ready  = ~in_valid_reg | ready_c[0];
    assign req_stall = ~in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && req_valid)
        begin
            op_reg   <= op;
            a_reg    <= a;
            b_reg    <= b;
            prod_reg <= $signed(a) * $signed(b);
        end
    end

    always_comb
    begin
        sum      = {a_reg[W-1], a_reg} + {b_reg[W-1], b_reg};
        prod_rnd = PW'(prod_reg) + RND_HALF;
        abs_a    = a_reg[W-1] ? (~a_reg + W'(1)) : a_reg;
        abs_b    = b_reg[W-1] ? (~b_reg + W'(1)) : b_reg;
        case (op_reg)
            OP_ADD:
            begin
                if (sum > SAT_HI)
                begin
                    prep_res = SAT_HI[W-1:0];
                end
                else if (sum < SAT_LO)
                begin
                    prep_res = SAT_LO[W-1:0];
                end
                else
                begin
                    prep_res = sum[W-1:0];
                end
            end
            OP_SUB:
            begin
                prep_res = a_reg - b_reg;
            end
            OP_MUL:
            begin
                prep_res = prod_rnd[FRAC_BITS+W-1:FRAC_BITS];
            end
            default:
            begin
                prep_res = '0;
            end
        endcase
    end

    // magnitude of the scaled and rounded dividend
    assign valid_c[0]   = in_valid_reg;
    assign ctl_c[0].op  = op_reg;
    assign ctl_c[0].neg = a_reg[W-1] ^ b_reg[W-1];
    assign ctl_c[0].dz  = (b_reg == '0);
    assign rem_c[0]     = '0;
    assign quo_c[0]     = {abs_a, {FRAC_BITS{1'b0}}} + MW'(abs_b >> 1);
    assign dvs_c[0]     = abs_b;
    assign res_c[0]     = prep_res;

    for (genvar i = 0; i < MW; i++)
    begin : g_div
        q14alu_div_stage #(
            .DVS_W (W),
            .QUO_W (MW)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_c[i]),
            .up_ready (ready_c[i]),
            .up_ctl   (ctl_c[i]),
            .up_rem   (rem_c[i]),
            .up_quo   (quo_c[i]),
            .up_dvs   (dvs_c[i]),
            .up_res   (res_c[i]),
            .dn_valid (valid_c[i+1]),
            .dn_ready (ready_c[i+1]),
            .dn_ctl   (ctl_c[i+1]),
            .dn_rem   (rem_c[i+1]),
            .dn_quo   (quo_c[i+1]),
            .dn_dvs   (dvs_c[i+1]),
            .dn_res   (res_c[i+1])
        );
    end

    assign out_ready   = ~out_valid_reg | ~rsp_stall;
    assign ready_c[MW] = out_ready;

    always_comb
    begin
        quo_low = quo_c[MW][W-1:0];
        if (ctl_c[MW].op == OP_DIV)
        begin
            if (ctl_c[MW].dz)
            begin
                final_res = '0;
            end
            else if (ctl_c[MW].neg)
            begin
                final_res = ~quo_low + W'(1);
            end
            else
            begin
                final_res = quo_low;
            end
        end
        else
        begin
            final_res = res_c[MW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= valid_c[MW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && valid_c[MW])
        begin
            result_reg <= final_res;
            dz_reg     <= (ctl_c[MW].op == OP_DIV) && ctl_c[MW].dz;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign result      = result_reg;
    assign div_by_zero = dz_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench for q14_fixed_point_alu, directed and random transfers
// predicts each Q2.14 result, compares it in order, varies idling and back-pressure
// depends on q14alu_pkg and the q14_fixed_point_alu rtl
`timescale 1ns / 1ps

module tb_top;
    import q14alu_pkg::*;

    localparam int FRAC_BITS   = 14;
    localparam int WORD_BITS   = 16;
    localparam int LATENCY     = WORD_BITS + FRAC_BITS + 2;
    localparam int STALL_LIMIT = 2000;
    localparam longint SAT_LIMIT  = (longint'(1) << (WORD_BITS - 1)) - 1;
    localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);

    typedef struct {
        logic [WORD_BITS-1:0] value;
        logic                 dz;
    } alu_outcome_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    op_t                  op_in = OP_ADD;
    logic [WORD_BITS-1:0] a_in = '0;
    logic [WORD_BITS-1:0] b_in = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [WORD_BITS-1:0] result;
    logic                 div_by_zero;

    alu_outcome_t results_due[$];
    int fail_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    q14_fixed_point_alu #(
        .FRAC_BITS(FRAC_BITS),
        .WORD_BITS(WORD_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .op(op_in),
        .a(a_in),
        .b(b_in),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .result(result),
        .div_by_zero(div_by_zero)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic alu_outcome_t q14_compute(op_t o, logic [WORD_BITS-1:0] x,
                                                 logic [WORD_BITS-1:0] y);
        longint sa;
        longint sb;
        longint acc;
        longint half;
        alu_outcome_t r;
        sa = longint'($signed(x));
        sb = longint'($signed(y));
        r.dz = 1'b0;
        case (o)
            OP_ADD:
            begin
                acc = sa + sb;
                if (acc > SAT_LIMIT)
                    acc = SAT_LIMIT;
                if (acc < -SAT_LIMIT)
                    acc = -SAT_LIMIT;
            end
            OP_SUB:
                acc = sa - sb;
            OP_MUL:
                acc = (sa * sb + ROUND_HALF) >>> FRAC_BITS;
            default:
            begin
                if (sb == 0)
                begin
                    acc = 0;
                    r.dz = 1'b1;
                end
                else
                begin
                    acc = sa * (longint'(1) << FRAC_BITS);
                    half = sb / 2;
                    if ((acc >= 0) == (sb >= 0))
                        acc = acc + half;
                    else
                        acc = acc - half;
                    acc = acc / sb;
                end
            end
        endcase
        r.value = acc[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_operand();
        logic [WORD_BITS-1:0] v;
        case ($urandom_range(7))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = 16'h0000;
            3: v = ($urandom_range(1)) ? 16'($urandom_range(64)) : -16'($urandom_range(64));
            4: v = ($urandom_range(1)) ? 16'h4000 : 16'hC000;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // one transfer on the request side, with random idle cycles ahead of it
    task automatic issue_op(input op_t o, input logic [WORD_BITS-1:0] x,
                            input logic [WORD_BITS-1:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            op_in = op_t'($urandom_range(3));
            a_in = 16'($urandom);
            b_in = 16'($urandom);
        end
        @(negedge clk);
        req_valid = 1'b1;
        op_in = o;
        a_in = x;
        b_in = y;
        do
            @(posedge clk);
        while (req_stall);
        results_due.push_back(q14_compute(o, x, y));
    endtask

    task automatic issue_random(input int n);
        repeat (n)
            issue_op(op_t'($urandom_range(3)), rand_operand(), rand_operand());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid = 1'b0;
        wait (results_due.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // response side: stall pattern plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else
            rsp_stall = ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        alu_outcome_t due;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result transfer: result %h div_by_zero %b",
                       result, div_by_zero);
                fail_count++;
            end
            else
            begin
                due = results_due.pop_front();
                if (result !== due.value)
                begin
                    $error("result: expected %h actual %h", due.value, result);
                    fail_count++;
                end
                if (div_by_zero !== due.dz)
                begin
                    $error("div_by_zero: expected %b actual %b", due.dz, div_by_zero);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("q14_fixed_point_alu regression: fail");
            $finish;
        end
    end

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        issue_op(OP_ADD, 16'h7FFF, 16'h7FFF);
        issue_op(OP_ADD, 16'h8000, 16'h8000);
        issue_op(OP_ADD, 16'h8000, 16'h0000);
        issue_op(OP_ADD, 16'h4000, 16'hC000);
        issue_op(OP_SUB, 16'h8000, 16'h0001);
        issue_op(OP_SUB, 16'h7FFF, 16'hFFFF);
        issue_op(OP_SUB, 16'h0000, 16'h8000);
        issue_op(OP_MUL, 16'h8000, 16'h8000);
        issue_op(OP_MUL, 16'h7FFF, 16'h7FFF);
        issue_op(OP_MUL, 16'hFFFF, 16'h0001);
        issue_op(OP_MUL, 16'h4000, 16'hC000);
        issue_op(OP_DIV, 16'h0000, 16'h0000);
        issue_op(OP_DIV, 16'h8000, 16'h0000);
        issue_op(OP_DIV, 16'h7FFF, 16'h0000);
        issue_op(OP_DIV, 16'h8000, 16'hFFFF);
        issue_op(OP_DIV, 16'h7FFF, 16'h0001);
        issue_op(OP_DIV, 16'h0000, 16'hFFFD);
        issue_op(OP_DIV, 16'hFFFF, 16'h0003);
        issue_op(OP_DIV, 16'h0001, 16'hFFFD);
        issue_op(OP_DIV, 16'hFFFF, 16'hFFFD);
        issue_op(OP_DIV, 16'h4000, 16'h8000);
        issue_op(OP_DIV, 16'h8000, 16'h7FFF);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int n);
        send_idle_pct = idle;
        stall_pct = stall;
        issue_random(n);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering, so the pipe fills
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 200;
        issue_random(60);
        wait_drained();
    endtask

    // sender pauses until every result is back, then resumes
    task automatic test_drain_pause();
        send_idle_pct = 20;
        stall_pct = 20;
        issue_random(25);
        wait_drained();
        issue_random(25);
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_traffic(0, 0, 90);
        test_random_traffic(48, 0, 90);
        test_random_traffic(0, 48, 90);
        test_random_traffic(34, 34, 90);
        test_backpressure();
        test_drain_pause();
        if (fail_count == 0)
            $display("q14_fixed_point_alu regression: pass");
        else
            $display("q14_fixed_point_alu regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/q14alu_pkg.sv
rtl/q14alu_div_stage.sv
rtl/q14_fixed_point_alu.sv
tb/sv/tb_top.sv
